// File: hw/rtl/qmd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmd_pkg
// Shared constants and the term table for the quaternion multiply/divide
// pipeline.
// ----------------------------------------------------------------------------
package qmd_pkg;

  // Default component format: Q2.14
  localparam int COMP_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 14;

  // Operation codes carried in tuser
  localparam logic KIND_MUL = 1'b0;
  localparam logic KIND_DIV = 1'b1;

  // Hamilton product terms per result component (x, y, z, w):
  // index into a, index into b, subtract flag
  localparam logic [1:0] TERM_A [4][4] = '{
    '{2'd0, 2'd3, 2'd1, 2'd2},
    '{2'd1, 2'd3, 2'd2, 2'd0},
    '{2'd2, 2'd3, 2'd0, 2'd1},
    '{2'd3, 2'd0, 2'd1, 2'd2}
  };
  localparam logic [1:0] TERM_B [4][4] = '{
    '{2'd3, 2'd0, 2'd2, 2'd1},
    '{2'd3, 2'd1, 2'd0, 2'd2},
    '{2'd3, 2'd2, 2'd1, 2'd0},
    '{2'd3, 2'd0, 2'd1, 2'd2}
  };
  localparam logic TERM_SUB [4][4] = '{
    '{1'b0, 1'b0, 1'b0, 1'b1},
    '{1'b0, 1'b0, 1'b0, 1'b1},
    '{1'b0, 1'b0, 1'b0, 1'b1},
    '{1'b0, 1'b1, 1'b1, 1'b1}
  };

endpackage

// File: hw/rtl/quaternion_multiply_divide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_multiply_divide
// Fixed-point quaternion Hamilton product and quotient, fully pipelined.
// ----------------------------------------------------------------------------
// One item is accepted per cycle unless the output stalls, and every item
// gives one result. The depth is set by the quotient: one restoring-division
// stage per quotient bit, behind a multiply stage, a summing stage, a
// rounding/numerator stage and a range-check stage. Multiply items ride
// through the same stages so results leave in order. The whole pipe
// advances together whenever the output register is empty or being taken;
// it holds when the output stalls.
// Multiply rounds to nearest with ties upward, divide rounds to nearest with
// ties away from zero, results saturate and set overflow, and a divide by a
// zero quaternion returns zeros with div_by_zero set.
module quaternion_multiply_divide #(
  parameter int COMP_WIDTH = qmd_pkg::COMP_WIDTH_DEF,
  parameter int FRAC_BITS  = qmd_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // tdata: a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, zero fill
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((8*COMP_WIDTH+7)/8)*8-1:0]     in_tdata,
  // tuser: kind
  input  logic                                  in_tuser,
  // tdata: r_x, r_y, r_z, r_w
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [((4*COMP_WIDTH+7)/8)*8-1:0]     out_tdata,
  // tuser: overflow, div_by_zero
  output logic [1:0]                            out_tuser
);

  localparam int W   = COMP_WIDTH;
  localparam int PW  = 2*W;            // one product
  localparam int SW  = 2*W + 3;        // sum of four products
  localparam int NRW = 2*W + 1;        // norm, unsigned
  localparam int CW  = 3*W + FRAC_BITS + 3; // numerator / shifted divisor
  localparam int OTW = ((4*W+7)/8)*8;

  localparam logic signed [SW-1:0] MAXS = SW'((64'sd1 <<< (W-1)) - 64'sd1);
  localparam logic signed [SW-1:0] MINS = -SW'(64'sd1 <<< (W-1));
  localparam logic signed [SW-1:0] RND  = SW'(64'sd1 <<< (FRAC_BITS-1));
  localparam logic [W-1:0] QMAXP = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] QMAXN = {1'b1, {(W-1){1'b0}}};

  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // Unpack operands
  logic signed [W-1:0] op_a [4];
  logic signed [W-1:0] op_b [4];
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      op_a[c] = in_tdata[c*W +: W];
      op_b[c] = in_tdata[(4+c)*W +: W];
    end
  end

  // Stage 1: all products
  logic                 v1_r;
  logic                 kind1_r;
  logic signed [PW-1:0] prod1_r [4][4];
  logic signed [PW-1:0] nprod1_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind1_r <= in_tuser;
      for (int c = 0; c < 4; c++) begin
        nprod1_r[c] <= op_b[c] * op_b[c];
        for (int t = 0; t < 4; t++) begin
          prod1_r[c][t] <= op_a[qmd_pkg::TERM_A[c][t]] * op_b[qmd_pkg::TERM_B[c][t]];
        end
      end
    end
  end

  // Stage 2: signed sums and norm
  logic                 v2_r;
  logic                 kind2_r;
  logic signed [SW-1:0] sum2_r [4];
  logic [NRW-1:0]       norm2_r;
  logic signed [SW-1:0] sum2_nxt [4];
  logic [NRW-1:0]       norm2_nxt;

  always_comb begin
    logic sub;
    norm2_nxt = '0;
    for (int c = 0; c < 4; c++) begin
      norm2_nxt = norm2_nxt + NRW'(nprod1_r[c]);
      sum2_nxt[c] = '0;
      for (int t = 0; t < 4; t++) begin
        // conjugate of b flips the sign of every vector term in a divide
        sub = qmd_pkg::TERM_SUB[c][t] ^
              ((kind1_r == qmd_pkg::KIND_DIV) && (qmd_pkg::TERM_B[c][t] != 2'd3));
        if (sub) begin
          sum2_nxt[c] = sum2_nxt[c] - SW'(prod1_r[c][t]);
        end else begin
          sum2_nxt[c] = sum2_nxt[c] + SW'(prod1_r[c][t]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind2_r <= kind1_r;
      norm2_r <= norm2_nxt;
      for (int c = 0; c < 4; c++) sum2_r[c] <= sum2_nxt[c];
    end
  end

  // Stage 3: multiply rounding and saturation; divide numerator
  logic          v3_r;
  logic          kind3_r;
  logic          dz3_r;
  logic [W-1:0]  mres3_r [4];
  logic          movf3_r;
  logic          neg3_r [4];
  logic [CW-1:0] num3_r [4];
  logic [CW-1:0] den3_r;

  logic [W-1:0]  mres3_nxt [4];
  logic          movf3_nxt;
  logic [CW-1:0] num3_nxt [4];

  always_comb begin
    logic signed [SW-1:0] rs;
    logic [SW-1:0]        mag;
    movf3_nxt = 1'b0;
    for (int c = 0; c < 4; c++) begin
      rs = (sum2_r[c] + RND) >>> FRAC_BITS;
      if (rs > MAXS) begin
        mres3_nxt[c] = QMAXP;
        movf3_nxt    = 1'b1;
      end else if (rs < MINS) begin
        mres3_nxt[c] = QMAXN;
        movf3_nxt    = 1'b1;
      end else begin
        mres3_nxt[c] = rs[W-1:0];
      end
      mag = sum2_r[c][SW-1] ? SW'(-sum2_r[c]) : SW'(sum2_r[c]);
      num3_nxt[c] = (CW'(mag[NRW-1:0]) << FRAC_BITS) + CW'(norm2_r >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind3_r <= kind2_r;
      dz3_r   <= (kind2_r == qmd_pkg::KIND_DIV) && (norm2_r == '0);
      movf3_r <= movf3_nxt;
      den3_r  <= CW'(norm2_r);
      for (int c = 0; c < 4; c++) begin
        mres3_r[c] <= mres3_nxt[c];
        neg3_r[c]  <= sum2_r[c][SW-1];
        num3_r[c]  <= num3_nxt[c];
      end
    end
  end

  // Stage 4: range check, then one quotient bit per stage
  logic          dv_v_r    [W+1];
  logic          dv_kind_r [W+1];
  logic          dv_dz_r   [W+1];
  logic          dv_movf_r [W+1];
  logic [W-1:0]  dv_mres_r [W+1][4];
  logic          dv_neg_r  [W+1][4];
  logic          dv_sat_r  [W+1][4];
  logic [CW-1:0] dv_rem_r  [W+1][4];
  logic [W-1:0]  dv_q_r    [W+1][4];
  logic [CW-1:0] dv_den_r  [W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (adv) begin
      dv_v_r[0] <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_kind_r[0] <= kind3_r;
      dv_dz_r[0]   <= dz3_r;
      dv_movf_r[0] <= movf3_r;
      dv_den_r[0]  <= den3_r;
      for (int c = 0; c < 4; c++) begin
        dv_mres_r[0][c] <= mres3_r[c];
        dv_neg_r[0][c]  <= neg3_r[c];
        dv_sat_r[0][c]  <= num3_r[c] >= (den3_r << W);
        dv_rem_r[0][c]  <= num3_r[c];
        dv_q_r[0][c]    <= '0;
      end
    end
  end

  for (genvar k = 0; k < W; k++) begin : g_div
    localparam int BIT = W - 1 - k;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k+1] <= 1'b0;
      end else if (adv) begin
        dv_v_r[k+1] <= dv_v_r[k];
      end
    end

    // Subtract the shifted divisor where it fits and set the quotient bit
    always_ff @(posedge clk) begin
      logic [CW-1:0] dsh;
      if (adv) begin
        dsh = dv_den_r[k] << BIT;
        dv_kind_r[k+1] <= dv_kind_r[k];
        dv_dz_r[k+1]   <= dv_dz_r[k];
        dv_movf_r[k+1] <= dv_movf_r[k];
        dv_den_r[k+1]  <= dv_den_r[k];
        for (int c = 0; c < 4; c++) begin
          dv_mres_r[k+1][c] <= dv_mres_r[k][c];
          dv_neg_r[k+1][c]  <= dv_neg_r[k][c];
          dv_sat_r[k+1][c]  <= dv_sat_r[k][c];
          if (dv_rem_r[k][c] >= dsh) begin
            dv_rem_r[k+1][c]    <= dv_rem_r[k][c] - dsh;
            dv_q_r[k+1][c]      <= dv_q_r[k][c] | (W'(1) << BIT);
          end else begin
            dv_rem_r[k+1][c]    <= dv_rem_r[k][c];
            dv_q_r[k+1][c]      <= dv_q_r[k][c];
          end
        end
      end
    end
  end

  // Output register: pick multiply or signed, saturated quotient
  logic [W-1:0] res_nxt [4];
  logic         ovf_nxt;

  always_comb begin
    ovf_nxt = 1'b0;
    for (int c = 0; c < 4; c++) begin
      if (dv_kind_r[W] == qmd_pkg::KIND_MUL) begin
        res_nxt[c] = dv_mres_r[W][c];
      end else if (dv_dz_r[W]) begin
        res_nxt[c] = '0;
      end else if (dv_neg_r[W][c]) begin
        if (dv_sat_r[W][c] || (dv_q_r[W][c] > QMAXN)) begin
          res_nxt[c] = QMAXN;
          ovf_nxt    = 1'b1;
        end else begin
          res_nxt[c] = -dv_q_r[W][c];
        end
      end else begin
        if (dv_sat_r[W][c] || (dv_q_r[W][c] > QMAXP)) begin
          res_nxt[c] = QMAXP;
          ovf_nxt    = 1'b1;
        end else begin
          res_nxt[c] = dv_q_r[W][c];
        end
      end
    end
    if (dv_kind_r[W] == qmd_pkg::KIND_MUL) begin
      ovf_nxt = dv_movf_r[W];
    end
  end

  logic         out_valid_r;
  logic [W-1:0] res_r [4];
  logic         ovf_r;
  logic         dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_v_r[W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ovf_r <= ovf_nxt;
      dz_r  <= dv_dz_r[W];
      for (int c = 0; c < 4; c++) res_r[c] <= res_nxt[c];
    end
  end

  // Pack result
  assign out_tvalid = out_valid_r;
  assign out_tuser  = {dz_r, ovf_r};
  assign out_tdata  = OTW'({res_r[3], res_r[2], res_r[1], res_r[0]});

endmodule
